@@ rtl/kupc_pkg.sv @@
// ----------------------------------------------------------------------------
// kupc_pkg
// Shared types and constants of the key use policy check core.
// ----------------------------------------------------------------------------
package kupc_pkg;

    localparam int KEY_COUNT_DEF = 256;
    localparam int TIME_BITS_DEF = 48;
    localparam int TIME_W        = 48;   // width of the time ports
    localparam int KEY_W         = 8;    // width of the key index port
    localparam int KEY_SPAN      = 256;  // keys reachable through the index port
    localparam int CMD_DEPTH     = 4;
    localparam int RES_DEPTH     = 2;

    typedef logic [TIME_W-1:0] t_time;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_PURPOSE  = 3'd1,
        ST_NOT_YET  = 3'd2,
        ST_EXPIRED  = 3'd3,
        ST_TOO_MANY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        KIND_ACTIVE = 3'd0,
        KIND_USAGE  = 3'd1,
        KIND_ORIG   = 3'd2,
        KIND_GAP    = 3'd3,
        KIND_SINGLE = 3'd4,
        KIND_OTHER  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        PURP_ENCRYPT = 2'd0,
        PURP_DECRYPT = 2'd1,
        PURP_SIGN    = 2'd2,
        PURP_VERIFY  = 2'd3
    } t_purpose;

    // One classified parameter as it waits between front and back
    typedef struct packed {
        t_kind            kind;
        logic [KEY_W-1:0] slot;
        t_status          pre_status;
        t_time            value;
        t_time            now;
        logic             last;
    } t_cmd;

endpackage

@@ rtl/kupc_fifo.sv @@
// ----------------------------------------------------------------------------
// kupc_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module kupc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/kupc_front.sv @@
// ----------------------------------------------------------------------------
// kupc_front
// Accepts parameter beats, folds the key index into the key range, masks
// the times, settles the checks that need no record and queues the result.
// ----------------------------------------------------------------------------
module kupc_front import kupc_pkg::*; #(
    parameter int KEY_COUNT = KEY_COUNT_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [2:0]       i_req_type,
    input  logic [KEY_W-1:0] i_key_index,
    input  logic [1:0]       i_purpose,
    input  logic             i_purpose_present,
    input  logic [TIME_W-1:0] i_param_value,
    input  logic [TIME_W-1:0] i_current_time,
    input  logic             i_last_param,
    output t_cmd             o_cmd,
    output logic             o_cmd_valid,
    input  logic             i_cmd_pop
);

    localparam int    TW        = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
    localparam t_time TIME_MASK = {TIME_W{1'b1}} >> (TIME_W - TW);

    // Remainder by compare and subtract, one shifted multiple per step
    function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic [31:0]      d;
        r = k;
        for (int i = KEY_W - 1; i >= 0; i--) begin
            d = 32'(KEY_COUNT) << i;
            if (32'(r) >= d) begin
                r = r - d[KEY_W-1:0];
            end
        end
        return r;
    endfunction

    t_cmd     w_cmd;
    t_purpose w_purpose;
    logic     w_empty;

    assign w_purpose = t_purpose'(i_purpose);

    always_comb begin
        w_cmd.slot  = fold_key(i_key_index);
        w_cmd.value = i_param_value & TIME_MASK;
        w_cmd.now   = i_current_time & TIME_MASK;
        w_cmd.last  = i_last_param;
        unique case (i_req_type)
            3'd0:    w_cmd.kind = KIND_ACTIVE;
            3'd1:    w_cmd.kind = KIND_USAGE;
            3'd2:    w_cmd.kind = KIND_ORIG;
            3'd3:    w_cmd.kind = KIND_GAP;
            3'd4:    w_cmd.kind = KIND_SINGLE;
            default: w_cmd.kind = KIND_OTHER;
        endcase
        w_cmd.pre_status = ST_OK;
        if (!i_purpose_present) begin
            w_cmd.pre_status = ST_PURPOSE;
        end else begin
            unique case (w_cmd.kind)
                KIND_ACTIVE: begin
                    if (w_cmd.now < w_cmd.value) w_cmd.pre_status = ST_NOT_YET;
                end
                KIND_USAGE: begin
                    if (w_purpose == PURP_VERIFY && w_cmd.now > w_cmd.value)
                        w_cmd.pre_status = ST_EXPIRED;
                end
                KIND_ORIG: begin
                    if (w_purpose == PURP_SIGN && w_cmd.now > w_cmd.value)
                        w_cmd.pre_status = ST_EXPIRED;
                end
                default: w_cmd.pre_status = ST_OK;
            endcase
        end
    end

    kupc_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (w_empty)
    );

    assign o_cmd_valid = !w_empty;

endmodule

@@ rtl/kupc_back.sv @@
// ----------------------------------------------------------------------------
// kupc_back
// Runs the record checks against the per-key use table, keeps the first
// error of a request and records the use time on a clean final beat.
// ----------------------------------------------------------------------------
module kupc_back import kupc_pkg::*; #(
    parameter int KEY_COUNT = KEY_COUNT_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_valid,
    output logic    o_cmd_pop,
    output logic    o_res_push,
    output t_status o_res_status,
    input  logic    i_res_full
);

    localparam int DEPTH = (KEY_COUNT < KEY_SPAN) ? KEY_COUNT : KEY_SPAN;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;

    logic [TW-1:0] r_time_mem [DEPTH];
    logic [DEPTH-1:0] r_flag;
    logic          r_s2_v;
    t_cmd          r_s2;
    t_status       r_run;
    logic [TW-1:0] r_rd_time;
    logic          r_byp;
    logic [TW-1:0] r_byp_time;

    logic          w_stall, w_adv, w_done, w_wr, w_flag;
    logic [AW-1:0] w_s2_addr, w_hd_addr;
    t_time         w_rec_time;
    t_status       w_check, w_fold;

    assign w_stall    = r_s2_v && r_s2.last && i_res_full;
    assign w_adv      = !w_stall;
    assign w_done     = r_s2_v && !w_stall;
    assign o_cmd_pop  = w_adv && i_cmd_valid;
    assign w_s2_addr  = r_s2.slot[AW-1:0];
    assign w_hd_addr  = i_cmd.slot[AW-1:0];
    assign w_flag     = r_flag[w_s2_addr];
    assign w_rec_time = t_time'(r_byp ? r_byp_time : r_rd_time);

    always_comb begin
        w_check = r_s2.pre_status;
        if (r_s2.pre_status == ST_OK) begin
            unique case (r_s2.kind)
                KIND_GAP: begin
                    // a current time behind the recorded time is a negative gap
                    if (w_flag && (r_s2.now < w_rec_time ||
                                   (r_s2.now - w_rec_time) < r_s2.value))
                        w_check = ST_TOO_MANY;
                end
                KIND_SINGLE: begin
                    if (w_flag) w_check = ST_TOO_MANY;
                end
                default: w_check = r_s2.pre_status;
            endcase
        end
        w_fold = (r_run == ST_OK) ? w_check : r_run;
    end

    assign w_wr         = w_done && r_s2.last && (w_fold == ST_OK);
    assign o_res_push   = w_done && r_s2.last;
    assign o_res_status = w_fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_run  <= ST_OK;
            r_flag <= '0;
        end else begin
            if (w_adv) begin
                r_s2_v <= i_cmd_valid;
            end
            if (w_done) begin
                r_run <= r_s2.last ? ST_OK : w_fold;
            end
            if (w_wr) begin
                r_flag[w_s2_addr] <= 1'b1;
            end
        end
    end

    // Hold the beat and its table read while the result side stalls
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2       <= i_cmd;
            r_byp      <= w_wr && (w_s2_addr == w_hd_addr);
            r_byp_time <= r_s2.now[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_time_mem[w_s2_addr] <= r_s2.now[TW-1:0];
        end
        if (w_adv) begin
            r_rd_time <= r_time_mem[w_hd_addr];
        end
    end

endmodule

@@ rtl/key_use_policy_check_core.sv @@
// ----------------------------------------------------------------------------
// key_use_policy_check_core
// Checks one key use against time limits and the per-key use record.
// ----------------------------------------------------------------------------
// A request is a run of parameter beats pushed on the input queue side
// (push, full); the beat with i_last_param high closes the request.
// Each beat is classified in the front, waits in a four-entry queue and is
// then checked in the back against the per-key record table. The first
// error of a request is kept; the closing beat yields one status beat on
// the result queue side (empty, pop), and on success the current time
// is recorded for that key.
// Throughput: one beat per cycle, but a closing beat waits while the result
// queue is full; set by the status fold and the one-read, one-write record
// memory with write-to-read bypass. A closing beat passes the command queue
// and the back stage register, and its status the result queue, before a pop.
// When the receiver stalls, the two-entry result queue fills, the back
// holds its beat, and the command queue absorbs up to four more beats
// before full rises.
// Reset clears the queues, the running status and every key's used flag;
// the block takes beats in the next cycle.
// ----------------------------------------------------------------------------
module key_use_policy_check_core import kupc_pkg::*; #(
    parameter int KEY_COUNT = KEY_COUNT_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [2:0]        i_req_type,
    input  logic [KEY_W-1:0]  i_key_index,
    input  logic [1:0]        i_purpose,
    input  logic              i_purpose_present,
    input  logic [TIME_W-1:0] i_param_value,
    input  logic [TIME_W-1:0] i_current_time,
    input  logic              i_last_param,
    output logic              empty,
    input  logic              pop,
    output logic [2:0]        o_status
);

    t_cmd    w_cmd;
    logic    w_cmd_valid, w_cmd_pop;
    logic    w_res_push, w_res_full;
    t_status w_res_status;

    kupc_front #(
        .KEY_COUNT (KEY_COUNT),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_req_type        (i_req_type),
        .i_key_index       (i_key_index),
        .i_purpose         (i_purpose),
        .i_purpose_present (i_purpose_present),
        .i_param_value     (i_param_value),
        .i_current_time    (i_current_time),
        .i_last_param      (i_last_param),
        .o_cmd             (w_cmd),
        .o_cmd_valid       (w_cmd_valid),
        .i_cmd_pop         (w_cmd_pop)
    );

    kupc_back #(
        .KEY_COUNT (KEY_COUNT),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cmd_valid  (w_cmd_valid),
        .o_cmd_pop    (w_cmd_pop),
        .o_res_push   (w_res_push),
        .o_res_status (w_res_status),
        .i_res_full   (w_res_full)
    );

    kupc_fifo #(
        .WIDTH ($bits(t_status)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_status),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_status),
        .o_empty (empty)
    );

endmodule
